[rtl/pnc_pkg.sv]
package pnc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    localparam int CFG_W = 9;
    localparam int OP_W = 2;
    localparam int IN_IDX_W = 8;
    localparam int CHAN_W = 8;
    localparam int COLOR_W = 4 * CHAN_W;
    localparam int OUT_IDX_W = 8;
    localparam int DIST_W = 10;

    localparam logic [CFG_W-1:0] COLORS_RESET = CFG_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_EXACT   = 2'd1,
        OP_CLOSEST = 2'd2
    } op_t;

    typedef struct packed {
        logic             start;
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic stop;
    } status_t;

endpackage

[rtl/palette_nearest_color_search.sv]
// Palette nearest-color search.
// Slave channel (s_tvalid/s_tready): s_tuser holds the operation (load entry,
// exact find, closest find); s_tdata holds entry index and RGBA channels.
// A load writes one palette entry in the cycle it is accepted and gives no
// word on the master channel. Operation code 3 is dropped.
// A find scans entries 0 to N-1 (N is colors_in_use saturated to the palette
// depth), one palette memory read per cycle, and gives one word on the master
// channel: m_tuser is the found flag, m_tdata holds match index and distance.
// The word passes through these steps: the palette reads, a compare of the
// last read and an output load. An exact match at an entry stops the scan
// early; with no entries in use the find goes straight to the output load.
// The slave channel opens again as the word reaches the output register, so
// a find holds it closed until then, while a load or a dropped word leaves it
// open; the next item is taken while a word still waits. A stalled receiver
// holds the word on m_tdata; a finished find then waits until the output
// register frees before the slave opens.
// The config channel writes colors_in_use; write it only while idle.
// Reset (aresetn low, synchronous) sets colors_in_use to 256, drops any
// pending word and returns to idle; palette contents are kept undefined.
module palette_nearest_color_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_index, red, green, blue, alpha
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // match_index, distance, zero fill
    output logic [0:0]  m_tuser,   // found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // colors_in_use
);

    pnc_pkg::cmd_t                   cmd;
    pnc_pkg::status_t                status;
    logic                            out_found;
    logic [pnc_pkg::OUT_IDX_W-1:0]   out_index;
    logic [pnc_pkg::DIST_W-1:0]      out_distance;

    pnc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    pnc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_op         (s_tuser),
        .s_index      (s_tdata[7:0]),
        .s_color      (s_tdata[39:8]),
        .out_found    (out_found),
        .out_index    (out_index),
        .out_distance (out_distance)
    );

    assign m_tuser = out_found;
    assign m_tdata = {6'd0, out_distance, out_index};

`ifndef ASSERT_OFF
    a_no_read_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !s_tready)
        else $error("palette read while slave channel is open");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrites a pending word");

    a_find_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == pnc_pkg::OP_EXACT || s_tuser == pnc_pkg::OP_CLOSEST))
        |=> !s_tready)
        else $error("slave channel open during a find");

    a_load_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == pnc_pkg::OP_LOAD) |=> !cmd.out_load)
        else $error("load produced a result");
`endif

endmodule

[rtl/pnc_ctrl.sv]
module pnc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pnc_pkg::OP_W-1:0]      s_op,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pnc_pkg::CFG_W-1:0]     cfg_data,
    input  pnc_pkg::status_t              status,
    output pnc_pkg::cmd_t                 cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam int SAT_W = (pnc_pkg::CFG_W > pnc_pkg::CNT_W) ? pnc_pkg::CFG_W : pnc_pkg::CNT_W;
    localparam logic [SAT_W-1:0] DEPTH_SAT = SAT_W'(pnc_pkg::PALETTE_DEPTH);

    state_t                       state_reg, state_next;
    logic [pnc_pkg::CFG_W-1:0]    colors_reg, colors_next;
    logic [pnc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [pnc_pkg::IDX_W-1:0]    addr_reg, addr_next;
    logic                         m_valid_reg, m_valid_next;

    logic                         accept;
    logic                         last_addr;
    logic [pnc_pkg::CNT_W-1:0]    count_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign last_addr = (pnc_pkg::CNT_W'(addr_reg) + pnc_pkg::CNT_W'(1)) == count_reg;

    always_comb begin
        if (SAT_W'(colors_reg) > DEPTH_SAT) begin
            count_sat = pnc_pkg::CNT_W'(pnc_pkg::PALETTE_DEPTH);
        end else begin
            count_sat = pnc_pkg::CNT_W'(colors_reg);
        end
    end

    always_comb begin
        cmd.start    = accept;
        cmd.wr_en    = accept && (s_op == pnc_pkg::OP_LOAD);
        cmd.rd_en    = (state_reg == ST_SCAN);
        cmd.rd_addr  = addr_reg;
        cmd.out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    always_comb begin
        state_next   = state_reg;
        colors_next  = colors_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg;

        if (cfg_valid && cfg_ready) begin
            colors_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op) inside
                        pnc_pkg::OP_EXACT, pnc_pkg::OP_CLOSEST: begin
                            count_next = count_sat;
                            addr_next  = '0;
                            if (count_sat == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                addr_next = addr_reg + pnc_pkg::IDX_W'(1);
                if (status.stop) begin
                    state_next = ST_DONE;
                end else if (last_addr) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (cmd.out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            colors_reg  <= pnc_pkg::COLORS_RESET;
            count_reg   <= '0;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            colors_reg  <= colors_next;
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/pnc_datapath.sv]
module pnc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pnc_pkg::cmd_t                     cmd,
    output pnc_pkg::status_t                  status,
    input  logic [pnc_pkg::OP_W-1:0]          s_op,
    input  logic [pnc_pkg::IN_IDX_W-1:0]      s_index,
    input  logic [pnc_pkg::COLOR_W-1:0]       s_color,
    output logic                              out_found,
    output logic [pnc_pkg::OUT_IDX_W-1:0]     out_index,
    output logic [pnc_pkg::DIST_W-1:0]        out_distance
);

    logic [pnc_pkg::COLOR_W-1:0]  mem [pnc_pkg::PALETTE_DEPTH];

    logic [pnc_pkg::COLOR_W-1:0]  query_reg;
    logic                         closest_reg;
    logic [pnc_pkg::COLOR_W-1:0]  rd_data_reg;
    logic [pnc_pkg::IDX_W-1:0]    rd_idx_reg;
    logic                         rd_valid_reg;
    logic                         hit_reg;
    logic                         stop_reg;
    logic [pnc_pkg::IDX_W-1:0]    best_idx_reg;
    logic [pnc_pkg::DIST_W-1:0]   best_dist_reg;

    logic [pnc_pkg::CHAN_W-1:0]   diff [4];
    logic [pnc_pkg::DIST_W-1:0]   sum_dist;
    logic                         equal;
    logic                         compare;

    assign status.stop = stop_reg;
    assign equal   = (rd_data_reg == query_reg);
    assign compare = rd_valid_reg && !stop_reg;

    always_comb begin
        logic [pnc_pkg::CHAN_W-1:0] a;
        logic [pnc_pkg::CHAN_W-1:0] b;
        sum_dist = '0;
        for (int k = 0; k < 4; k++) begin
            a = rd_data_reg[k*pnc_pkg::CHAN_W +: pnc_pkg::CHAN_W];
            b = query_reg[k*pnc_pkg::CHAN_W +: pnc_pkg::CHAN_W];
            diff[k] = (a > b) ? (a - b) : (b - a);
            sum_dist = sum_dist + pnc_pkg::DIST_W'(diff[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (32'(s_index) < pnc_pkg::PALETTE_DEPTH)) begin
            mem[pnc_pkg::IDX_W'(s_index)] <= s_color;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            stop_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.start) begin
                hit_reg  <= 1'b0;
                stop_reg <= 1'b0;
            end else if (compare) begin
                if (equal) begin
                    hit_reg  <= 1'b1;
                    stop_reg <= 1'b1;
                end else if (closest_reg) begin
                    hit_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cmd.rd_addr;
        if (cmd.start) begin
            query_reg     <= s_color;
            closest_reg   <= (s_op == pnc_pkg::OP_CLOSEST);
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end else if (compare) begin
            if (equal) begin
                best_idx_reg  <= rd_idx_reg;
                best_dist_reg <= '0;
            end else if (closest_reg && (!hit_reg || sum_dist < best_dist_reg)) begin
                best_idx_reg  <= rd_idx_reg;
                best_dist_reg <= sum_dist;
            end
        end
        if (cmd.out_load) begin
            out_found    <= hit_reg;
            out_index    <= pnc_pkg::OUT_IDX_W'(best_idx_reg);
            out_distance <= best_dist_reg;
        end
    end

endmodule
